### sv/ttu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent unit package
// Shared widths, the sequencer state type, multiplier step codes and the
// command word of the shared square root and divide unit.
// ----------------------------------------------------------------------------
package ttu_pkg;

   localparam int OUT_FRAC_BITS_DEF = 14;

   localparam int COORD_W = 32;
   localparam int EDGE_W  = 33;
   localparam int PROD_W  = 66;
   localparam int MAG_W   = 66;
   localparam int M_W     = 30;
   localparam int SUM_W   = 62;
   localparam int OPND_W  = 62;
   localparam int REM_W   = 35;
   localparam int RES_W   = 32;
   localparam int LEN_W   = 31;
   localparam int OUT_W   = 16;

   localparam int SQRT_STEPS = 31;
   localparam int CNT_W      = 5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_MWAIT,
      ST_CHECK,
      ST_NORM,
      ST_SQ,
      ST_SQWAIT,
      ST_SQRT_GO,
      ST_SQRT,
      ST_DIV_GO,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef logic [3:0] mul_step_type;

   localparam mul_step_type MUL_DET_P = 4'd0;
   localparam mul_step_type MUL_DET_Q = 4'd1;
   localparam mul_step_type MUL_TX_P  = 4'd2;
   localparam mul_step_type MUL_TX_Q  = 4'd3;
   localparam mul_step_type MUL_TY_P  = 4'd4;
   localparam mul_step_type MUL_TY_Q  = 4'd5;
   localparam mul_step_type MUL_TZ_P  = 4'd6;
   localparam mul_step_type MUL_TZ_Q  = 4'd7;
   localparam mul_step_type MUL_SQ_X  = 4'd8;
   localparam mul_step_type MUL_SQ_Y  = 4'd9;
   localparam mul_step_type MUL_SQ_Z  = 4'd10;

   typedef struct packed {
      logic start;
      logic is_sqrt;
   } sd_cmd_type;

endpackage

### sv/ttu_sqrt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent unit: shared square root and divide
// One compare-and-subtract datapath, used two bits a cycle for the integer
// square root and one bit a cycle for the rounded divide.
// ----------------------------------------------------------------------------
module ttu_sqrt_div #(
   parameter int OUT_FRAC_BITS = ttu_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ttu_pkg::sd_cmd_type             cmd,
   input  logic [ttu_pkg::OPND_W-1:0]      operand,
   input  logic [ttu_pkg::LEN_W-1:0]       divisor,
   output logic                            done,
   output logic [ttu_pkg::RES_W-1:0]       result
);

   logic                          busy_ff;
   logic                          done_ff;
   logic                          is_sqrt_ff;
   logic [ttu_pkg::CNT_W-1:0]     cnt_ff;
   logic [ttu_pkg::REM_W-1:0]     rem_ff;
   logic [ttu_pkg::OPND_W-1:0]    opnd_ff;
   logic [ttu_pkg::RES_W-1:0]     root_ff;
   logic [ttu_pkg::LEN_W-1:0]     divisor_ff;

   logic [ttu_pkg::REM_W-1:0]     rem_sh;
   logic [ttu_pkg::REM_W-1:0]     trial;
   logic                          ge;

   always_comb begin
      if (is_sqrt_ff) begin
         rem_sh = {rem_ff[ttu_pkg::REM_W-3:0], opnd_ff[ttu_pkg::OPND_W-1 -: 2]};
         trial  = {1'b0, root_ff, 2'b01};
      end else begin
         rem_sh = {rem_ff[ttu_pkg::REM_W-2:0], opnd_ff[ttu_pkg::OPND_W-1]};
         trial  = ttu_pkg::REM_W'(divisor_ff);
      end
      ge = (rem_sh >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == '0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         is_sqrt_ff <= cmd.is_sqrt;
         root_ff    <= '0;
         divisor_ff <= divisor;
         if (cmd.is_sqrt) begin
            cnt_ff  <= ttu_pkg::CNT_W'(ttu_pkg::SQRT_STEPS - 1);
            rem_ff  <= '0;
            opnd_ff <= operand;
         end else begin
            cnt_ff  <= ttu_pkg::CNT_W'(OUT_FRAC_BITS);
            rem_ff  <= ttu_pkg::REM_W'(operand >> (OUT_FRAC_BITS + 1));
            opnd_ff <= operand << (ttu_pkg::OPND_W - 1 - OUT_FRAC_BITS);
         end
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         rem_ff  <= ge ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[ttu_pkg::RES_W-2:0], ge};
         opnd_ff <= is_sqrt_ff ? (opnd_ff << 2) : (opnd_ff << 1);
      end
   end

   assign done   = done_ff;
   assign result = root_ff;

endmodule

### sv/triangle_tangent_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent unit
// Holds two corners, then forms the unit tangent of the triangle on the third
// corner with one shared multiplier and one shared square root/divide unit.
// ----------------------------------------------------------------------------
// First and second corners of a triangle are registered as they are taken.
// The third corner starts the determinant and tangent products, the normalising shift
// (eight bits a step, then one bit), the squares, the 31-step square root and the
// three bit-serial divides; a degenerate triangle goes straight to its result word.
// A word is taken only while the sequencer is idle; a third corner also waits for the
// previous result word to leave. Synchronous active-high reset clears control state.
// ----------------------------------------------------------------------------
module triangle_tangent_unit #(
   parameter int OUT_FRAC_BITS = ttu_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [ttu_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [ttu_pkg::COORD_W-1:0] req_pos_y,
   input  logic signed [ttu_pkg::COORD_W-1:0] req_pos_z,
   input  logic signed [ttu_pkg::COORD_W-1:0] req_tex_u,
   input  logic signed [ttu_pkg::COORD_W-1:0] req_tex_v,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ttu_pkg::OUT_W-1:0]  rsp_tangent_x,
   output logic signed [ttu_pkg::OUT_W-1:0]  rsp_tangent_y,
   output logic signed [ttu_pkg::OUT_W-1:0]  rsp_tangent_z,
   output logic                              rsp_degenerate
);

   localparam int NUM_W = ttu_pkg::M_W + OUT_FRAC_BITS + 1;

   ttu_pkg::state_type            state_ff, state_in;
   ttu_pkg::mul_step_type         mul_idx_ff, mul_idx_in;
   logic                          mul_issue;
   logic [1:0]                    div_k_ff, div_k_in;
   ttu_pkg::sd_cmd_type           sd_cmd;
   logic                          sd_done;
   logic [ttu_pkg::RES_W-1:0]     sd_result;
   logic [ttu_pkg::OPND_W-1:0]    sd_operand;

   logic [1:0]                    corner_ff;
   logic [ttu_pkg::COORD_W-1:0]   held_pos_ff [6];
   logic [ttu_pkg::COORD_W-1:0]   held_tex_ff [4];

   logic signed [ttu_pkg::EDGE_W-1:0] e1_ff [3];
   logic signed [ttu_pkg::EDGE_W-1:0] e2_ff [3];
   logic signed [ttu_pkg::EDGE_W-1:0] d1u_ff, d1v_ff, d2u_ff, d2v_ff;

   logic signed [ttu_pkg::EDGE_W-1:0] mul_a, mul_b;
   logic signed [ttu_pkg::PROD_W-1:0] prod_ff;
   logic                          prod_valid_ff;
   ttu_pkg::mul_step_type         prod_idx_ff;
   logic signed [ttu_pkg::PROD_W-1:0] first_ff;
   logic signed [ttu_pkg::PROD_W:0]   diff;
   logic [ttu_pkg::MAG_W-1:0]     diff_mag;

   logic                          det_zero_ff, det_neg_ff;
   logic [ttu_pkg::MAG_W-1:0]     mag_ff [3];
   logic                          sign_ff [3];
   logic [ttu_pkg::MAG_W-1:0]     mag_or;
   logic [ttu_pkg::SUM_W-1:0]     sum_ff;
   logic [ttu_pkg::LEN_W-1:0]     len_ff;
   logic [ttu_pkg::LEN_W-1:0]     q_ff [3];
   logic                          deg_ff;
   logic                          degenerate_now;
   logic [ttu_pkg::M_W-1:0]       m_sel;
   logic [NUM_W-1:0]              num_w;

   logic                          rsp_valid_ff;
   logic [ttu_pkg::OUT_W-1:0]     rsp_tx_ff, rsp_ty_ff, rsp_tz_ff;
   logic                          rsp_deg_ff;
   logic                          req_take;
   logic [ttu_pkg::OUT_W-1:0]     out_val [3];

   assign req_ready = (state_ff == ttu_pkg::ST_IDLE) && ((corner_ff != 2'd2) || !rsp_valid_ff);
   assign req_take  = req_valid && req_ready;

   assign mag_or = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign degenerate_now = det_zero_ff || (mag_or == '0);
   assign m_sel = mag_ff[div_k_ff][ttu_pkg::MAG_W-1 -: ttu_pkg::M_W];
   assign num_w = NUM_W'({m_sel, {OUT_FRAC_BITS{1'b0}}}) + NUM_W'(len_ff[ttu_pkg::LEN_W-1:1]);

   always_comb begin
      state_in   = state_ff;
      mul_idx_in = mul_idx_ff;
      div_k_in   = div_k_ff;
      mul_issue  = 1'b0;
      sd_cmd     = '0;
      sd_operand = '0;
      unique case (state_ff)
         ttu_pkg::ST_IDLE: begin
            if (req_take && (corner_ff == 2'd2)) begin
               state_in   = ttu_pkg::ST_MUL;
               mul_idx_in = ttu_pkg::MUL_DET_P;
            end
         end
         ttu_pkg::ST_MUL: begin
            mul_issue  = 1'b1;
            mul_idx_in = mul_idx_ff + 1'b1;
            if (mul_idx_ff == ttu_pkg::MUL_TZ_Q) begin
               state_in = ttu_pkg::ST_MWAIT;
            end
         end
         ttu_pkg::ST_MWAIT: begin
            state_in = ttu_pkg::ST_CHECK;
         end
         ttu_pkg::ST_CHECK: begin
            state_in = degenerate_now ? ttu_pkg::ST_OUT : ttu_pkg::ST_NORM;
         end
         ttu_pkg::ST_NORM: begin
            if (mag_or[ttu_pkg::MAG_W-1]) begin
               state_in   = ttu_pkg::ST_SQ;
               mul_idx_in = ttu_pkg::MUL_SQ_X;
            end
         end
         ttu_pkg::ST_SQ: begin
            mul_issue  = 1'b1;
            mul_idx_in = mul_idx_ff + 1'b1;
            if (mul_idx_ff == ttu_pkg::MUL_SQ_Z) begin
               state_in = ttu_pkg::ST_SQWAIT;
            end
         end
         ttu_pkg::ST_SQWAIT: begin
            state_in = ttu_pkg::ST_SQRT_GO;
         end
         ttu_pkg::ST_SQRT_GO: begin
            sd_cmd.start   = 1'b1;
            sd_cmd.is_sqrt = 1'b1;
            sd_operand     = sum_ff;
            state_in       = ttu_pkg::ST_SQRT;
         end
         ttu_pkg::ST_SQRT: begin
            if (sd_done) begin
               state_in = ttu_pkg::ST_DIV_GO;
               div_k_in = 2'd0;
            end
         end
         ttu_pkg::ST_DIV_GO: begin
            sd_cmd.start = 1'b1;
            sd_operand   = ttu_pkg::OPND_W'(num_w);
            state_in     = ttu_pkg::ST_DIV;
         end
         ttu_pkg::ST_DIV: begin
            if (sd_done) begin
               if (div_k_ff == 2'd2) begin
                  state_in = ttu_pkg::ST_OUT;
               end else begin
                  state_in = ttu_pkg::ST_DIV_GO;
                  div_k_in = div_k_ff + 1'b1;
               end
            end
         end
         ttu_pkg::ST_OUT: begin
            state_in = ttu_pkg::ST_IDLE;
         end
         default: begin
            state_in = ttu_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ttu_pkg::ST_IDLE;
         mul_idx_ff <= ttu_pkg::MUL_DET_P;
         div_k_ff   <= 2'd0;
      end else begin
         state_ff   <= state_in;
         mul_idx_ff <= mul_idx_in;
         div_k_ff   <= div_k_in;
      end
   end

   // Corner capture; the third corner forms the edges and uv deltas at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= 2'd0;
         for (int i = 0; i < 6; i++) begin
            held_pos_ff[i] <= '0;
         end
         for (int i = 0; i < 4; i++) begin
            held_tex_ff[i] <= '0;
         end
      end else if (req_take) begin
         if (corner_ff == 2'd2) begin
            corner_ff <= 2'd0;
         end else begin
            corner_ff <= corner_ff + 1'b1;
            if (corner_ff == 2'd0) begin
               held_pos_ff[0] <= req_pos_x;
               held_pos_ff[1] <= req_pos_y;
               held_pos_ff[2] <= req_pos_z;
               held_tex_ff[0] <= req_tex_u;
               held_tex_ff[1] <= req_tex_v;
            end else begin
               held_pos_ff[3] <= req_pos_x;
               held_pos_ff[4] <= req_pos_y;
               held_pos_ff[5] <= req_pos_z;
               held_tex_ff[2] <= req_tex_u;
               held_tex_ff[3] <= req_tex_v;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && (corner_ff == 2'd2)) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= $signed({held_pos_ff[3+i][31], held_pos_ff[3+i]})
                      - $signed({held_pos_ff[i][31], held_pos_ff[i]});
         end
         e2_ff[0] <= $signed({req_pos_x[31], req_pos_x})
                   - $signed({held_pos_ff[0][31], held_pos_ff[0]});
         e2_ff[1] <= $signed({req_pos_y[31], req_pos_y})
                   - $signed({held_pos_ff[1][31], held_pos_ff[1]});
         e2_ff[2] <= $signed({req_pos_z[31], req_pos_z})
                   - $signed({held_pos_ff[2][31], held_pos_ff[2]});
         d1u_ff <= $signed({held_tex_ff[2][31], held_tex_ff[2]})
                 - $signed({held_tex_ff[0][31], held_tex_ff[0]});
         d1v_ff <= $signed({held_tex_ff[3][31], held_tex_ff[3]})
                 - $signed({held_tex_ff[1][31], held_tex_ff[1]});
         d2u_ff <= $signed({req_tex_u[31], req_tex_u})
                 - $signed({held_tex_ff[0][31], held_tex_ff[0]});
         d2v_ff <= $signed({req_tex_v[31], req_tex_v})
                 - $signed({held_tex_ff[1][31], held_tex_ff[1]});
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (mul_idx_ff)
         ttu_pkg::MUL_DET_P: begin mul_a = d1u_ff; mul_b = d2v_ff; end
         ttu_pkg::MUL_DET_Q: begin mul_a = d2u_ff; mul_b = d1v_ff; end
         ttu_pkg::MUL_TX_P:  begin mul_a = d2v_ff; mul_b = e1_ff[0]; end
         ttu_pkg::MUL_TX_Q:  begin mul_a = d1v_ff; mul_b = e2_ff[0]; end
         ttu_pkg::MUL_TY_P:  begin mul_a = d2v_ff; mul_b = e1_ff[1]; end
         ttu_pkg::MUL_TY_Q:  begin mul_a = d1v_ff; mul_b = e2_ff[1]; end
         ttu_pkg::MUL_TZ_P:  begin mul_a = d2v_ff; mul_b = e1_ff[2]; end
         ttu_pkg::MUL_TZ_Q:  begin mul_a = d1v_ff; mul_b = e2_ff[2]; end
         ttu_pkg::MUL_SQ_X: begin
            mul_a = $signed(ttu_pkg::EDGE_W'(mag_ff[0][ttu_pkg::MAG_W-1 -: ttu_pkg::M_W]));
            mul_b = mul_a;
         end
         ttu_pkg::MUL_SQ_Y: begin
            mul_a = $signed(ttu_pkg::EDGE_W'(mag_ff[1][ttu_pkg::MAG_W-1 -: ttu_pkg::M_W]));
            mul_b = mul_a;
         end
         ttu_pkg::MUL_SQ_Z: begin
            mul_a = $signed(ttu_pkg::EDGE_W'(mag_ff[2][ttu_pkg::MAG_W-1 -: ttu_pkg::M_W]));
            mul_b = mul_a;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= mul_issue;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= mul_a * mul_b;
      prod_idx_ff <= mul_idx_ff;
   end

   assign diff     = $signed({first_ff[ttu_pkg::PROD_W-1], first_ff})
                   - $signed({prod_ff[ttu_pkg::PROD_W-1], prod_ff});
   assign diff_mag = diff[ttu_pkg::PROD_W] ? ttu_pkg::MAG_W'(-diff) : ttu_pkg::MAG_W'(diff);

   // Product combine and square sum, then normalizing shift of the three magnitudes.
   always_ff @(posedge clock) begin
      if (prod_valid_ff) begin
         unique case (prod_idx_ff)
            ttu_pkg::MUL_DET_P, ttu_pkg::MUL_TX_P, ttu_pkg::MUL_TY_P,
            ttu_pkg::MUL_TZ_P: begin
               first_ff <= prod_ff;
            end
            ttu_pkg::MUL_DET_Q: begin
               det_zero_ff <= (diff == '0);
               det_neg_ff  <= diff[ttu_pkg::PROD_W];
            end
            ttu_pkg::MUL_TX_Q: begin
               mag_ff[0]  <= diff_mag;
               sign_ff[0] <= diff[ttu_pkg::PROD_W];
            end
            ttu_pkg::MUL_TY_Q: begin
               mag_ff[1]  <= diff_mag;
               sign_ff[1] <= diff[ttu_pkg::PROD_W];
            end
            ttu_pkg::MUL_TZ_Q: begin
               mag_ff[2]  <= diff_mag;
               sign_ff[2] <= diff[ttu_pkg::PROD_W];
            end
            ttu_pkg::MUL_SQ_X, ttu_pkg::MUL_SQ_Y, ttu_pkg::MUL_SQ_Z: begin
               sum_ff <= sum_ff + prod_ff[ttu_pkg::SUM_W-1:0];
            end
            default: begin
            end
         endcase
      end else if (state_ff == ttu_pkg::ST_CHECK) begin
         sum_ff <= '0;
         deg_ff <= degenerate_now;
      end else if (state_ff == ttu_pkg::ST_NORM) begin
         if (mag_or[ttu_pkg::MAG_W-1 -: 8] == '0) begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= mag_ff[i] << 8;
            end
         end else if (!mag_or[ttu_pkg::MAG_W-1]) begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= mag_ff[i] << 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ttu_pkg::ST_SQRT) && sd_done) begin
         len_ff <= sd_result[ttu_pkg::LEN_W-1:0];
      end
      if ((state_ff == ttu_pkg::ST_DIV) && sd_done) begin
         q_ff[div_k_ff] <= sd_result[ttu_pkg::LEN_W-1:0];
      end
   end

   ttu_sqrt_div #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_sqrt_div (
      .clock   (clock),
      .reset   (reset),
      .cmd     (sd_cmd),
      .operand (sd_operand),
      .divisor (len_ff),
      .done    (sd_done),
      .result  (sd_result)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_val[i] = (sign_ff[i] ^ det_neg_ff) ? (ttu_pkg::OUT_W'(0) - q_ff[i][ttu_pkg::OUT_W-1:0])
                                                 : q_ff[i][ttu_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ttu_pkg::ST_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ttu_pkg::ST_OUT) begin
         rsp_deg_ff <= deg_ff;
         rsp_tx_ff  <= deg_ff ? '0 : out_val[0];
         rsp_ty_ff  <= deg_ff ? '0 : out_val[1];
         rsp_tz_ff  <= deg_ff ? '0 : out_val[2];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tangent_x  = rsp_tx_ff;
   assign rsp_tangent_y  = rsp_ty_ff;
   assign rsp_tangent_z  = rsp_tz_ff;
   assign rsp_degenerate = rsp_deg_ff;

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ttu_pkg::ST_IDLE) |-> !req_ready)
      else $error("Input taken while the sequencer is busy.");

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ttu_pkg::ST_OUT) |-> !rsp_valid_ff)
      else $error("Result word written over one not yet taken.");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         ((rsp_tangent_x == '0) && (rsp_tangent_y == '0) && (rsp_tangent_z == '0)))
      else $error("Degenerate word carries a non-zero tangent.");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      sd_done |-> ((state_ff == ttu_pkg::ST_SQRT) || (state_ff == ttu_pkg::ST_DIV)))
      else $error("Square root or divide finished outside its wait state.");

endmodule

### tb/sv/triangle_tangent_unit_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent unit checker
// Watches both channels of the tangent unit. It keeps its own copy of the
// held corners and predicts each result word when a third corner is taken.
// Each result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module triangle_tangent_unit_check #(
   parameter int OUT_FRAC_BITS = ttu_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic signed [ttu_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [ttu_pkg::COORD_W-1:0] req_pos_y,
   input  logic signed [ttu_pkg::COORD_W-1:0] req_pos_z,
   input  logic signed [ttu_pkg::COORD_W-1:0] req_tex_u,
   input  logic signed [ttu_pkg::COORD_W-1:0] req_tex_v,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [ttu_pkg::OUT_W-1:0]   rsp_tangent_x,
   input  logic signed [ttu_pkg::OUT_W-1:0]   rsp_tangent_y,
   input  logic signed [ttu_pkg::OUT_W-1:0]   rsp_tangent_z,
   input  logic                               rsp_degenerate,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 degenerate_seen
);

   typedef logic signed [ttu_pkg::COORD_W-1:0] coord_type;
   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic [ttu_pkg::OUT_W-1:0] tx;
      logic [ttu_pkg::OUT_W-1:0] ty;
      logic [ttu_pkg::OUT_W-1:0] tz;
      logic                      degen;
   } tangent_type;

   coord_type   corner_pos [2][3];
   coord_type   corner_uv  [2][2];
   int          corners_held;
   tangent_type tangent_queue [$];

   function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic tangent_type tangent_of(input coord_type p0 [3],
                                              input coord_type p1 [3],
                                              input coord_type p2 [3],
                                              input coord_type uv0 [2],
                                              input coord_type uv1 [2],
                                              input coord_type uv2 [2]);
      wide_type    e1 [3];
      wide_type    e2 [3];
      wide_type    t  [3];
      wide_type    a  [3];
      wide_type    d1u, d1v, d2u, d2v, det;
      logic [63:0] m  [3];
      logic [63:0] len, q, v;
      logic        flip, neg;
      int          maxlen, s;
      tangent_type r;
      logic [ttu_pkg::OUT_W-1:0] o [3];
      for (int i = 0; i < 3; i++) begin
         e1[i] = wide_type'(p1[i]) - wide_type'(p0[i]);
         e2[i] = wide_type'(p2[i]) - wide_type'(p0[i]);
      end
      d1u = wide_type'(uv1[0]) - wide_type'(uv0[0]);
      d1v = wide_type'(uv1[1]) - wide_type'(uv0[1]);
      d2u = wide_type'(uv2[0]) - wide_type'(uv0[0]);
      d2v = wide_type'(uv2[1]) - wide_type'(uv0[1]);
      det = d1u * d2v - d2u * d1v;
      for (int i = 0; i < 3; i++) t[i] = d2v * e1[i] - d1v * e2[i];
      r = '0;
      if (det == 0 || (t[0] == 0 && t[1] == 0 && t[2] == 0)) begin
         r.degen = 1'b1;
         return r;
      end
      flip = det < 0;
      maxlen = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = t[i] < 0 ? -t[i] : t[i];
         for (int k = 0; k < 128; k++) if (a[i][k] && k + 1 > maxlen) maxlen = k + 1;
      end
      s = maxlen - ttu_pkg::M_W;
      for (int i = 0; i < 3; i++) begin
         if (s > 0) m[i] = 64'(a[i] >>> s);
         else       m[i] = 64'(a[i] <<< (-s));
      end
      len = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << OUT_FRAC_BITS) + (len >> 1)) / len;
         neg = (t[i] < 0) != flip;
         v = neg ? -q : q;
         o[i] = v[ttu_pkg::OUT_W-1:0];
      end
      r.tx = o[0];
      r.ty = o[1];
      r.tz = o[2];
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("%0t: tangent mismatch on %s: got %0d, expected %0d", $realtime, field,
               got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      coord_type   p2 [3];
      coord_type   uv2 [2];
      tangent_type want;
      tangent_type made;
      if (reset) begin
         corners_held = 0;
         fail_count = 0;
         degenerate_seen = 0;
         tangent_queue.delete();
         for (int i = 0; i < 2; i++) begin
            for (int k = 0; k < 3; k++) corner_pos[i][k] = '0;
            corner_uv[i][0] = '0;
            corner_uv[i][1] = '0;
         end
      end else begin
         if (req_valid && req_ready) begin
            p2[0] = req_pos_x;
            p2[1] = req_pos_y;
            p2[2] = req_pos_z;
            uv2[0] = req_tex_u;
            uv2[1] = req_tex_v;
            if (corners_held < 2) begin
               corner_pos[corners_held] = p2;
               corner_uv[corners_held] = uv2;
               corners_held++;
            end else begin
               corners_held = 0;
               made = tangent_of(corner_pos[0], corner_pos[1], p2,
                                 corner_uv[0], corner_uv[1], uv2);
               tangent_queue = {tangent_queue, made};
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (tangent_queue.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               want = tangent_queue.pop_front();
               if (want.degen) degenerate_seen++;
               if (rsp_tangent_x !== want.tx)
                  report_mismatch("tangent_x", rsp_tangent_x, $signed(want.tx));
               if (rsp_tangent_y !== want.ty)
                  report_mismatch("tangent_y", rsp_tangent_y, $signed(want.ty));
               if (rsp_tangent_z !== want.tz)
                  report_mismatch("tangent_z", rsp_tangent_z, $signed(want.tz));
               if (rsp_degenerate !== want.degen)
                  report_mismatch("degenerate", rsp_degenerate, want.degen);
            end
         end
      end
      pending = tangent_queue.size();
   end

endmodule

### tb/sv/triangle_tangent_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent unit testbench
// Feeds directed and random triangles to the tangent unit with random gaps
// and output stalls; the checker beside the block predicts every result word.
// ----------------------------------------------------------------------------
module triangle_tangent_unit_test;

   typedef logic signed [ttu_pkg::COORD_W-1:0] coord_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   coord_type req_pos_x, req_pos_y, req_pos_z, req_tex_u, req_tex_v;
   logic      rsp_valid;
   logic      rsp_ready;
   logic signed [ttu_pkg::OUT_W-1:0] rsp_tangent_x, rsp_tangent_y, rsp_tangent_z;
   logic      rsp_degenerate;
   int        fail_count;
   int        pending;
   int        degenerate_seen;
   int        vertices_sent;
   logic      steady;

   triangle_tangent_unit dut (.*);

   triangle_tangent_unit_check u_check (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_tex_u(req_tex_u), .req_tex_v(req_tex_v), .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready), .rsp_tangent_x(rsp_tangent_x),
      .rsp_tangent_y(rsp_tangent_y), .rsp_tangent_z(rsp_tangent_z),
      .rsp_degenerate(rsp_degenerate), .fail_count(fail_count), .pending(pending),
      .degenerate_seen(degenerate_seen));

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Timed out with %0d result words outstanding.", pending);
      $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else       rsp_ready <= steady || ($urandom_range(99) >= 9);
   end

   task automatic send_vertex(input coord_type px, input coord_type py, input coord_type pz,
                              input coord_type tu, input coord_type tv);
      while (!steady && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_tex_u <= tu;
      req_tex_v <= tv;
      do @(posedge clock); while (!req_ready);
      vertices_sent++;
   endtask

   function automatic coord_type rand_coord(input int kind);
      unique case (kind)
         0:       return $signed($urandom);
         1:       return $signed($urandom_range(4000)) - 2000;
         2:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return ($signed($urandom_range(511)) - 256) <<< 12;
      endcase
   endfunction

   task automatic send_random_triangle();
      int kind;
      kind = $urandom_range(3);
      for (int c = 0; c < 3; c++) begin
         send_vertex(rand_coord(kind), rand_coord(kind), rand_coord(kind),
                     rand_coord(kind), rand_coord(kind));
      end
   endtask

   initial begin
      coord_type hi, lo;
      hi = 32'sh7FFF_FFFF;
      lo = 32'sh8000_0000;
      vertices_sent = 0;
      steady = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_pos_x <= '0;
      req_pos_y <= '0;
      req_pos_z <= '0;
      req_tex_u <= '0;
      req_tex_v <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_vertex(0, 0, 0, 0, 0);
      send_vertex(32'sh10000, 0, 0, 32'sh10000, 0);
      send_vertex(0, 32'sh10000, 0, 0, 32'sh10000);
      send_vertex(0, 0, 0, 0, 0);
      send_vertex(32'sh10000, 0, 0, 0, 32'sh10000);
      send_vertex(0, 32'sh10000, 0, 32'sh10000, 0);
      send_vertex(5, 6, 7, 100, 100);
      send_vertex(9, 9, 9, 100, 100);
      send_vertex(1, 2, 3, 100, 100);
      send_vertex(3, 3, 3, 0, 0);
      send_vertex(3, 3, 3, 50, 0);
      send_vertex(3, 3, 3, 0, 50);
      send_vertex(lo, lo, lo, lo, lo);
      send_vertex(hi, hi, lo, hi, lo);
      send_vertex(lo, hi, hi, lo, hi);
      send_vertex(hi, hi, hi, hi, hi);
      send_vertex(lo, lo, hi, lo, lo);
      send_vertex(hi, lo, lo, hi, hi);
      send_vertex(-1, -1, -1, -1, -1);
      send_vertex(0, 0, 1, 0, 1);
      send_vertex(1, 0, 0, 1, 0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      for (int n = 0; n < 266; n++) begin
         steady = (n >= 100 && n < 140);
         send_random_triangle();
      end
      send_vertex($signed($urandom), $signed($urandom), $signed($urandom),
                  $signed($urandom), $signed($urandom));
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Covered %0d vertices (%0d whole triangles, %0d degenerate), with extreme,",
               vertices_sent, vertices_sent / 3, degenerate_seen);
      $display("small and full-range coordinates under random gaps and output stalls.");
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
